[design/qyfr_pkg.sv]
// ----------------------------------------------------------------------------
// qyfr_pkg: shared constants and types for the quaternion yaw frame rotation
// Fixed-point widths, CORDIC arctangent table and pipeline stage records.
// ----------------------------------------------------------------------------
`default_nettype none

package qyfr_pkg;

   // CORDIC iteration count, limited to the length of the arctangent table
   localparam int CORDIC_ITERATIONS = 16;
   localparam int ATAN_LEN          = 24;
   localparam int NUM_ITER          = (CORDIC_ITERATIONS > ATAN_LEN) ? ATAN_LEN :
                                      (CORDIC_ITERATIONS < 1) ? 1 : CORDIC_ITERATIONS;

   // field widths
   localparam int QUAT_W  = 16;
   localparam int VEC_CW  = 16;
   localparam int YAW_W   = 16;
   localparam int LOCAL_W = 17;

   // internal widths (angles in 2^-30 rad)
   localparam int PROD_W = 32;
   localparam int SC_W   = 36;
   localparam int VX_W   = 37;
   localparam int ANG_W  = 35;
   localparam int ROT_W  = 36;
   localparam int GAIN_W = 31;

   localparam logic signed [ANG_W-1:0]  PI_Q30      = 35'sd3373259426;
   localparam logic signed [ANG_W-1:0]  HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [GAIN_W-1:0] INV_GAIN    = 31'sd652032875;
   localparam logic signed [SC_W-1:0]   ONE_Q28     = 36'sd268435456;
   localparam logic signed [YAW_W-1:0]  YAW_LIMIT   = 16'sd25736;
   localparam logic signed [LOCAL_W-1:0] LOCAL_LIMIT = 17'sd46341;

   // configuration register indexes
   localparam logic REG_VECTOR_X = 1'b0;
   localparam logic REG_VECTOR_Y = 1'b1;

   // floor(atan(2^-i) * 2^30)
   localparam logic [29:0] ATAN_Q30 [ATAN_LEN] = '{
      30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
      30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
      30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
      30'd262143,    30'd131071,    30'd65535,     30'd32767,
      30'd16383,     30'd8191,      30'd4095,      30'd2047,
      30'd1023,      30'd511,       30'd255,       30'd127
   };

   // vectoring stage record
   typedef struct packed {
      logic signed [VX_W-1:0]  x;
      logic signed [VX_W-1:0]  y;
      logic signed [ANG_W-1:0] z;
      logic                    zero;
   } vec_stage_type;

   // rotation stage record
   typedef struct packed {
      logic signed [ROT_W-1:0] x;
      logic signed [ROT_W-1:0] y;
      logic signed [ANG_W-1:0] z;
      logic signed [YAW_W-1:0] yaw;
   } rot_stage_type;

endpackage

`default_nettype wire

[design/quaternion_yaw_frame_rotation_top.sv]
// ----------------------------------------------------------------------------
// quaternion_yaw_frame_rotation_top: yaw from quaternion, planar rotation
// Extracts yaw = atan2(2(wz+xy), 1-2(y^2+z^2)) by CORDIC vectoring, then
// rotates the configured body-frame vector by that yaw by CORDIC rotation.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one quaternion per beat (w, x, y, z in Q2.14).
//   rsp_ channel returns one beat per quaternion: yaw (Q3.13), local x and y
//   (Q3.14), in input order.
//   csr_ port writes vector_x (index 0) or vector_y (index 1); write only
//   while no beat is in flight.
// Throughput: one beat per cycle while no skid entry is held;
//   every CORDIC iteration has its own stage.
// Stall: when rsp_tready is low the response register holds and a one-entry
//   skid register catches the next finished beat; the whole pipeline and
//   req_tready then hold until the skid entry drains. No beat is lost.
// Reset: synchronous, clears all valid bits; vector_x returns to 1.0 and
//   vector_y to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_yaw_frame_rotation_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,
   // rsp_tdata: yaw[15:0], local_x[32:16], local_y[49:33], zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);
   import qyfr_pkg::*;

   localparam int N = NUM_ITER;

   logic en;
   logic push;
   logic pop;

   // configuration registers and scaled vector
   logic signed [VEC_CW-1:0]        vector_x_ff, vector_y_ff;
   logic signed [VEC_CW+GAIN_W-1:0] gain_x_prod, gain_y_prod;
   logic signed [ROT_W-1:0]         scale_x_ff, scale_y_ff;

   // front stages
   logic                     prod_vld_ff;
   logic signed [PROD_W-1:0] p_wz_ff, p_xy_ff, p_yy_ff, p_zz_ff;
   logic                     sc_vld_ff;
   logic signed [SC_W-1:0]   s_ff, c_ff;
   logic signed [SC_W-1:0]   s_in, c_in;

   // CORDIC stages
   vec_stage_type vec_ff [0:N];
   logic          vec_vld_ff [0:N];
   vec_stage_type vec_init_in;
   logic                    yaw_vld_ff;
   logic signed [YAW_W-1:0] yaw_ff;
   logic signed [YAW_W-1:0] yaw_in;
   logic signed [17:0]      yaw_shift;
   rot_stage_type rot_ff [0:N];
   logic          rot_vld_ff [0:N];
   rot_stage_type rot_init_in;

   // output side
   logic                      rsp_vld_ff, skid_vld_ff;
   logic [55:0]               rsp_data_ff, skid_data_ff;
   logic [55:0]               fin_data;
   logic signed [ROT_W-17:0]  lx_shift, ly_shift;
   logic signed [LOCAL_W-1:0] lx_clamp, ly_clamp;

   assign en         = !skid_vld_ff;
   assign req_tready = en;
   assign pop        = rsp_vld_ff && rsp_tready;
   assign push       = en && rot_vld_ff[N];

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         vector_x_ff <= 16'sd16384;
         vector_y_ff <= 16'sd0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_VECTOR_X: vector_x_ff <= csr_wdata;
            REG_VECTOR_Y: vector_y_ff <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // vector times 1/K, in 2^-30 units; settles long before any item reaches it
   assign gain_x_prod = vector_x_ff * INV_GAIN;
   assign gain_y_prod = vector_y_ff * INV_GAIN;
   always_ff @(posedge clock) begin
      scale_x_ff <= ROT_W'(gain_x_prod >>> 14);
      scale_y_ff <= ROT_W'(gain_y_prod >>> 14);
   end

   // stage 1: products
   always_ff @(posedge clock) begin
      if (reset) prod_vld_ff <= 1'b0;
      else if (en) prod_vld_ff <= req_tvalid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         p_wz_ff <= $signed(req_tdata[15:0])  * $signed(req_tdata[63:48]);
         p_xy_ff <= $signed(req_tdata[31:16]) * $signed(req_tdata[47:32]);
         p_yy_ff <= $signed(req_tdata[47:32]) * $signed(req_tdata[47:32]);
         p_zz_ff <= $signed(req_tdata[63:48]) * $signed(req_tdata[63:48]);
      end
   end

   // stage 2: sine and cosine terms, exact
   always_comb begin
      s_in = (SC_W'(p_wz_ff) + SC_W'(p_xy_ff)) <<< 1;
      c_in = ONE_Q28 - ((SC_W'(p_yy_ff) + SC_W'(p_zz_ff)) <<< 1);
   end
   always_ff @(posedge clock) begin
      if (reset) sc_vld_ff <= 1'b0;
      else if (en) sc_vld_ff <= prod_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s_ff <= s_in;
         c_ff <= c_in;
      end
   end

   // stage 3: vectoring start, left half plane folded over by pi
   always_comb begin
      vec_init_in.zero = (s_ff == '0) && (c_ff == '0);
      if (c_ff < 0) begin
         vec_init_in.x = -VX_W'(c_ff);
         vec_init_in.y = -VX_W'(s_ff);
         vec_init_in.z = (s_ff >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
         vec_init_in.x = VX_W'(c_ff);
         vec_init_in.y = VX_W'(s_ff);
         vec_init_in.z = '0;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) vec_vld_ff[0] <= 1'b0;
      else if (en) vec_vld_ff[0] <= sc_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (en) vec_ff[0] <= vec_init_in;
   end

   // vectoring iterations, one per stage
   for (genvar i = 0; i < N; i++) begin : g_vec
      vec_stage_type stage_in;
      always_comb begin
         stage_in.zero = vec_ff[i].zero;
         if (vec_ff[i].y > 0) begin
            stage_in.x = vec_ff[i].x + (vec_ff[i].y >>> i);
            stage_in.y = vec_ff[i].y - (vec_ff[i].x >>> i);
            stage_in.z = vec_ff[i].z + ANG_W'(ATAN_Q30[i]);
         end else begin
            stage_in.x = vec_ff[i].x - (vec_ff[i].y >>> i);
            stage_in.y = vec_ff[i].y + (vec_ff[i].x >>> i);
            stage_in.z = vec_ff[i].z - ANG_W'(ATAN_Q30[i]);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) vec_vld_ff[i+1] <= 1'b0;
         else if (en) vec_vld_ff[i+1] <= vec_vld_ff[i];
      end
      always_ff @(posedge clock) begin
         if (en) vec_ff[i+1] <= stage_in;
      end
   end

   // yaw: round to Q3.13 and clamp
   assign yaw_shift = 18'((vec_ff[N].z + ANG_W'(65536)) >>> 17);
   always_comb begin
      priority if (vec_ff[N].zero)           yaw_in = '0;
      else if (yaw_shift > 18'(YAW_LIMIT))   yaw_in = YAW_LIMIT;
      else if (yaw_shift < -18'(YAW_LIMIT))  yaw_in = -YAW_LIMIT;
      else                                   yaw_in = YAW_W'(yaw_shift);
   end
   always_ff @(posedge clock) begin
      if (reset) yaw_vld_ff <= 1'b0;
      else if (en) yaw_vld_ff <= vec_vld_ff[N];
   end
   always_ff @(posedge clock) begin
      if (en) yaw_ff <= yaw_in;
   end

   // rotation start: fold angle into [-pi/2, pi/2]
   always_comb begin
      rot_init_in.yaw = yaw_ff;
      rot_init_in.z   = ANG_W'(yaw_ff) <<< 17;
      rot_init_in.x   = scale_x_ff;
      rot_init_in.y   = scale_y_ff;
      priority if (rot_init_in.z > HALF_PI_Q30) begin
         rot_init_in.z = rot_init_in.z - PI_Q30;
         rot_init_in.x = -scale_x_ff;
         rot_init_in.y = -scale_y_ff;
      end else if (rot_init_in.z < -HALF_PI_Q30) begin
         rot_init_in.z = rot_init_in.z + PI_Q30;
         rot_init_in.x = -scale_x_ff;
         rot_init_in.y = -scale_y_ff;
      end else begin
      end
   end
   always_ff @(posedge clock) begin
      if (reset) rot_vld_ff[0] <= 1'b0;
      else if (en) rot_vld_ff[0] <= yaw_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (en) rot_ff[0] <= rot_init_in;
   end

   // rotation iterations, one per stage
   for (genvar i = 0; i < N; i++) begin : g_rot
      rot_stage_type stage_in;
      always_comb begin
         stage_in.yaw = rot_ff[i].yaw;
         if (rot_ff[i].z >= 0) begin
            stage_in.x = rot_ff[i].x - (rot_ff[i].y >>> i);
            stage_in.y = rot_ff[i].y + (rot_ff[i].x >>> i);
            stage_in.z = rot_ff[i].z - ANG_W'(ATAN_Q30[i]);
         end else begin
            stage_in.x = rot_ff[i].x + (rot_ff[i].y >>> i);
            stage_in.y = rot_ff[i].y - (rot_ff[i].x >>> i);
            stage_in.z = rot_ff[i].z + ANG_W'(ATAN_Q30[i]);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) rot_vld_ff[i+1] <= 1'b0;
         else if (en) rot_vld_ff[i+1] <= rot_vld_ff[i];
      end
      always_ff @(posedge clock) begin
         if (en) rot_ff[i+1] <= stage_in;
      end
   end

   // final rounding to Q3.14 and clamp
   assign lx_shift = (ROT_W-16)'((rot_ff[N].x + ROT_W'(32768)) >>> 16);
   assign ly_shift = (ROT_W-16)'((rot_ff[N].y + ROT_W'(32768)) >>> 16);
   always_comb begin
      priority if (lx_shift > (ROT_W-16)'(LOCAL_LIMIT))       lx_clamp = LOCAL_LIMIT;
      else if (lx_shift < -(ROT_W-16)'(LOCAL_LIMIT))          lx_clamp = -LOCAL_LIMIT;
      else                                                    lx_clamp = LOCAL_W'(lx_shift);
      priority if (ly_shift > (ROT_W-16)'(LOCAL_LIMIT))       ly_clamp = LOCAL_LIMIT;
      else if (ly_shift < -(ROT_W-16)'(LOCAL_LIMIT))          ly_clamp = -LOCAL_LIMIT;
      else                                                    ly_clamp = LOCAL_W'(ly_shift);
      fin_data = {6'd0, ly_clamp, lx_clamp, rot_ff[N].yaw};
   end

   // response register with one-entry skid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (pop) skid_vld_ff <= 1'b0;
      end else if (push) begin
         if (!rsp_vld_ff || pop) rsp_vld_ff  <= 1'b1;
         else                    skid_vld_ff <= 1'b1;
      end else if (pop) begin
         rsp_vld_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (pop) rsp_data_ff <= skid_data_ff;
      end else if (push) begin
         if (!rsp_vld_ff || pop) rsp_data_ff  <= fin_data;
         else                    skid_data_ff <= fin_data;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   a_skid_needs_rsp : assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_vld_ff)
      else $error("skid entry held without a waiting response");
   a_skid_only_on_stall : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(rsp_vld_ff && !rsp_tready))
      else $error("skid filled although the response was free");
   a_yaw_range : assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> ($signed(rsp_data_ff[15:0]) <= YAW_LIMIT &&
                      $signed(rsp_data_ff[15:0]) >= -YAW_LIMIT))
      else $error("yaw outside [-pi, pi]");
   a_no_push_when_held : assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |=> !(skid_vld_ff && !$past(rsp_tready)) || $stable(skid_data_ff))
      else $error("skid entry overwritten while held");

endmodule

`default_nettype wire
